### rtl/core/fm_tuner_control_word_serializer_unit_defines.svh
// Assertion macros used by the port-level checker of the tuner control word serializer
`ifndef FM_TUNER_CONTROL_WORD_SERIALIZER_UNIT_DEFINES_SVH
`define FM_TUNER_CONTROL_WORD_SERIALIZER_UNIT_DEFINES_SVH

// Property checked only outside reset
`define FMTCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included
`define FMTCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fmtcw_pkg.sv
// Types and constants of the FM tuner control word serializer
package fmtcw_pkg;

  localparam int FreqWidth  = 28;
  localparam int AccWidth   = FreqWidth + 1;
  localparam int DivWidth   = 14;
  localparam int WordBits   = 25;
  localparam int CntWidth   = 5;
  localparam int FrameBytes = 6;
  localparam int ShWidth    = FrameBytes * 8;

  localparam logic [AccWidth-1:0] IfOffsetHz = AccWidth'(10700000);
  // 12.5 kHz times 2^14: at or above this every divider bit is set
  localparam logic [AccWidth-1:0] SatHz = AccWidth'(204800000);

  // floor(x / 3125) = (x * DivRecip) >> DivShift, exact for x < 2^26
  localparam int RecipWidth = 27;
  localparam int QuotInWidth = 26;
  localparam int ProdWidth = RecipWidth + QuotInWidth;
  localparam int DivShift = 38;
  localparam logic [RecipWidth-1:0] DivRecip = RecipWidth'(87960931);

  localparam int BitSearch   = 24;
  localparam int BitSearchUp = 23;
  localparam int BitMono     = 22;
  localparam int BitDx       = 19;
  localparam int BitSensHi   = 17;
  localparam int BitSensLo   = 16;

  localparam int UartShift = 7;
  localparam logic [7:0] UartSoh  = 8'h01;
  localparam logic [7:0] UartTune = 8'h02;

  typedef enum logic [3:0] {
    REG_MONO_MODE   = 4'd0,
    REG_DX_MODE     = 4'd1,
    REG_SENSITIVITY = 4'd2,
    REG_LINK_MODE   = 4'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    SENS_VERY_LOW = 4'd0,
    SENS_LOW      = 4'd1,
    SENS_MEDIUM   = 4'd2
  } sens_code_t;

  typedef struct packed {
    logic [FreqWidth-1:0] freq_hz;
    logic                 search;
    logic                 search_up;
  } req_t;

  typedef struct packed {
    logic       serial_bit;
    logic       pin_level;
    logic [7:0] byte_value;
    logic       is_byte;
    logic       last;
  } rsp_t;

endpackage

### rtl/core/fm_tuner_control_word_serializer_unit.sv
// Top level of the FM tuner control word serializer
//
// Request channel (req_valid/req_ready/req): one tune request per transaction,
// frequency in Hz plus search flags. Result channel (rsp_valid/rsp_ready/rsp):
// the frame, one result per transaction, last marks the final one.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready,
// writes mono, DX, sensitivity and link mode; write only while idle.
// Pipeline: request register (adds the IF), divider register (constant
// reciprocal multiply), then the frame shift register that drives rsp.
// A request passes the request and divider registers into the frame shift
// register, which gives one result per cycle while rsp_ready is high: 25
// results per frame in three-wire mode, 6 in UART mode. The two front stages
// take the next requests while a frame is still draining.
// Reset: pipeline emptied, registers to mono 0, DX 1, sensitivity 10,
// three-wire mode. A stalled receiver holds rsp steady; the front stages
// fill and then req_ready drops.
module fm_tuner_control_word_serializer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  fmtcw_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output fmtcw_pkg::rsp_t   rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [3:0]        cfg_data
);
  import fmtcw_pkg::*;

  // configuration
  logic       mono_mode;
  logic       dx_mode;
  logic [3:0] sensitivity_level;
  logic       link_mode;

  // stage 1: accumulator after IF offset
  logic                s1_valid;
  logic [AccWidth-1:0] s1_acc;
  logic                s1_search;
  logic                s1_up;

  // stage 2: divider
  logic                s2_valid;
  logic [DivWidth-1:0] s2_div;
  logic                s2_search;
  logic                s2_up;

  // frame shift register
  logic                ser_valid;
  logic [ShWidth-1:0]  sh;
  logic [CntWidth-1:0] cnt;
  logic                uart;

  logic                 ser_load;
  logic                 s2_load;
  logic                 s1_load;
  logic                 sat;
  logic [ProdWidth-1:0] prod;
  logic [DivWidth-1:0]  div_next;
  logic [WordBits-1:0]  word;
  logic [31:0]          uart_frame;
  logic [ShWidth-1:0]   sh_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode         <= 1'b0;
      dx_mode           <= 1'b1;
      sensitivity_level <= 4'd10;
      link_mode         <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        REG_MONO_MODE:   mono_mode         <= cfg_data[0];
        REG_DX_MODE:     dx_mode           <= cfg_data[0];
        REG_SENSITIVITY: sensitivity_level <= cfg_data;
        REG_LINK_MODE:   link_mode         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake chain: the frame register frees on its last result
  assign ser_load  = s2_valid && (!ser_valid || (rsp_ready && cnt == CntWidth'(1)));
  assign s2_load   = s1_valid && (!s2_valid || ser_load);
  assign req_ready = !s1_valid || s2_load;
  assign s1_load   = req_valid && req_ready;

  // divider: greedy 14-step search equals floor(acc / 12500), saturated
  assign sat      = s1_acc >= SatHz;
  assign prod     = ProdWidth'(s1_acc[QuotInWidth+1:2]) * ProdWidth'(DivRecip);
  assign div_next = sat ? {DivWidth{1'b1}} : prod[DivShift +: DivWidth];

  always_comb begin
    word = '0;
    word[DivWidth-1:0] = s2_div;
    word[BitSearch]    = s2_search;
    word[BitSearchUp]  = s2_search && s2_up;
    word[BitMono]      = mono_mode;
    word[BitDx]        = dx_mode || link_mode;
    case (sens_code_t'(sensitivity_level))
      SENS_VERY_LOW: begin
        word[BitSensHi] = 1'b1;
        word[BitSensLo] = 1'b1;
      end
      SENS_LOW:    word[BitSensLo] = 1'b1;
      SENS_MEDIUM: word[BitSensHi] = 1'b1;
      default: ;
    endcase
    uart_frame = 32'(word) << UartShift;
    if (link_mode) begin
      sh_next = {uart_frame, UartTune, UartSoh};
    end else begin
      sh_next = ShWidth'(word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      ser_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (ser_load) begin
        s2_valid <= 1'b0;
      end
      if (ser_load) begin
        ser_valid <= 1'b1;
      end else if (rsp_ready && cnt == CntWidth'(1)) begin
        ser_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_acc    <= AccWidth'(req.freq_hz) + IfOffsetHz;
      s1_search <= req.search;
      s1_up     <= req.search_up;
    end
    if (s2_load) begin
      s2_div    <= div_next;
      s2_search <= s1_search;
      s2_up     <= s1_up;
    end
    if (ser_load) begin
      sh   <= sh_next;
      uart <= link_mode;
      cnt  <= link_mode ? CntWidth'(FrameBytes) : CntWidth'(WordBits);
    end else if (ser_valid && rsp_ready) begin
      cnt <= cnt - CntWidth'(1);
      if (uart) begin
        sh <= sh >> 8;
      end else begin
        sh <= sh << 1;
      end
    end
  end

  assign rsp_valid      = ser_valid;
  assign rsp.serial_bit = !uart && sh[WordBits-1];
  assign rsp.pin_level  = !uart && !sh[WordBits-1];
  assign rsp.byte_value = uart ? sh[7:0] : 8'h00;
  assign rsp.is_byte    = uart;
  assign rsp.last       = cnt == CntWidth'(1);

endmodule

### rtl/core/fmtcw_checker.sv
// Port-level assertions for the tuner control word serializer, with bind
`include "fm_tuner_control_word_serializer_unit_defines.svh"

module fmtcw_checker (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input fmtcw_pkg::rsp_t rsp
);
  import fmtcw_pkg::*;

  `FMTCW_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "result changed while stalled")
  `FMTCW_ASSERT(a_pin_inverse, clk, rst, rsp_valid && !rsp.is_byte |-> rsp.pin_level != rsp.serial_bit && rsp.byte_value == 8'h00, "serial result fields inconsistent")
  `FMTCW_ASSERT(a_byte_quiet, clk, rst, rsp_valid && rsp.is_byte |-> !rsp.serial_bit && !rsp.pin_level, "byte result drives serial fields")
  `FMTCW_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp_valid, "result valid right after reset")

endmodule

bind fm_tuner_control_word_serializer_unit fmtcw_checker u_fmtcw_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

### sim/fm_tuner_control_word_serializer_unit_checker.sv
// Channel checker for the tuner control word serializer: predicts each frame and compares it
module fm_tuner_control_word_serializer_unit_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  fmtcw_pkg::req_t req,
  input  logic            rsp_valid,
  input  logic            rsp_ready,
  input  fmtcw_pkg::rsp_t rsp,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [3:0]      cfg_data,
  output int              owed,
  output int              fail_count,
  output int              requests_seen,
  output int              results_seen
);
  import fmtcw_pkg::*;

  localparam logic [31:0] FirstStepHz = 32'd102400000;

  logic       mono_q;
  logic       dx_q;
  logic       uart_q;
  logic [3:0] sens_q;
  rsp_t       frame_q[$];

  function automatic logic [WordBits-1:0] tune_word(req_t r, logic dx);
    logic [31:0]         acc;
    logic [31:0]         step;
    logic [WordBits-1:0] w;
    w    = '0;
    acc  = 32'(r.freq_hz) + 32'(IfOffsetHz);
    step = FirstStepHz;
    w[BitMono] = mono_q;
    w[BitDx]   = dx;
    case (sens_q)
      SENS_VERY_LOW: begin
        w[BitSensHi] = 1'b1;
        w[BitSensLo] = 1'b1;
      end
      SENS_LOW:    w[BitSensLo] = 1'b1;
      SENS_MEDIUM: w[BitSensHi] = 1'b1;
      default: ;
    endcase
    w[BitSearch]   = r.search;
    w[BitSearchUp] = r.search & r.search_up;
    // greedy divider: 102.4 MHz halving down to 12.5 kHz
    for (int k = DivWidth - 1; k >= 0; k--) begin
      if (acc >= step) begin
        w[k] = 1'b1;
        acc  = acc - step;
      end
      step = step >> 1;
    end
    return w;
  endfunction

  function automatic rsp_t make_result(logic sbit, logic [7:0] byte_val, logic is_b, logic lst);
    rsp_t s;
    s.serial_bit = sbit;
    s.pin_level  = is_b ? 1'b0 : ~sbit;
    s.byte_value = byte_val;
    s.is_byte    = is_b;
    s.last       = lst;
    return s;
  endfunction

  task automatic queue_frame(req_t r);
    logic [WordBits-1:0] w;
    logic [31:0]         uart_word;
    if (uart_q) begin
      // DX is always on in a UART frame
      uart_word = 32'(tune_word(r, 1'b1)) << UartShift;
      frame_q.push_back(make_result(1'b0, UartSoh, 1'b1, 1'b0));
      frame_q.push_back(make_result(1'b0, UartTune, 1'b1, 1'b0));
      for (int i = 0; i < 4; i++)
        frame_q.push_back(make_result(1'b0, uart_word[8*i +: 8], 1'b1, i == 3));
    end else begin
      w = tune_word(r, dx_q);
      for (int i = WordBits - 1; i >= 0; i--)
        frame_q.push_back(make_result(w[i], 8'h00, 1'b0, i == 0));
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      mono_q        = 1'b0;
      dx_q          = 1'b1;
      sens_q        = 4'd10;
      uart_q        = 1'b0;
      frame_q.delete();
      fail_count    = 0;
      requests_seen = 0;
      results_seen  = 0;
      owed         <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MONO_MODE:   mono_q = cfg_data[0];
          REG_DX_MODE:     dx_q   = cfg_data[0];
          REG_SENSITIVITY: sens_q = cfg_data;
          REG_LINK_MODE:   uart_q = cfg_data[0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (frame_q.size() == 0) begin
          $error("unexpected result transaction: %p", rsp);
          fail_count++;
        end else begin
          want = frame_q.pop_front();
          check_field("serial_bit", want.serial_bit, rsp.serial_bit);
          check_field("pin_level", want.pin_level, rsp.pin_level);
          check_field("byte_value", want.byte_value, rsp.byte_value);
          check_field("is_byte", want.is_byte, rsp.is_byte);
          check_field("last", want.last, rsp.last);
        end
      end
      if (req_valid && req_ready) begin
        requests_seen++;
        queue_frame(req);
      end
      owed <= frame_q.size();
    end
  end

endmodule

### sim/fm_tuner_control_word_serializer_unit_tb.sv
// Testbench top for the tuner control word serializer: stimulus, idling, watchdog and verdict
module fm_tuner_control_word_serializer_unit_tb;
  import fmtcw_pkg::*;

  localparam int IdleLimit     = 4000;
  localparam int HoldOffCycles = 400;
  localparam int ItemsPerPhase = 60;
  localparam int Phases        = 8;

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_ready;
  rsp_t       rsp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_index;
  logic [3:0] cfg_data;

  int owed;
  int fail_count;
  int requests_seen;
  int results_seen;
  int sender_idle_pct = 0;
  int rsp_stall_pct = 0;
  int quiet_cycles = 0;
  int settings_seen = 1;
  bit want_holdoff = 1'b0;

  always #2 clk = ~clk;

  fm_tuner_control_word_serializer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fm_tuner_control_word_serializer_unit_checker u_frame_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .owed          (owed),
    .fail_count    (fail_count),
    .requests_seen (requests_seen),
    .results_seen  (results_seen)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (want_holdoff) begin
        rsp_ready   <= 1'b0;
        want_holdoff = 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tune(req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [3:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every predicted result has been taken
  task automatic drain;
    req_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  task automatic set_regs(int p);
    logic       mono;
    logic       dx;
    logic       uart;
    logic [3:0] sens;
    case (p)
      1:       {mono, dx, sens, uart} = {1'b1, 1'b0, 4'd0, 1'b0};
      2:       {mono, dx, sens, uart} = {1'b0, 1'b1, 4'd1, 1'b1};
      3:       {mono, dx, sens, uart} = {1'b1, 1'b1, 4'd2, 1'b0};
      4:       {mono, dx, sens, uart} = {1'b0, 1'b0, 4'd15, 1'b1};
      5:       {mono, dx, sens, uart} = {1'b1, 1'b0, 4'd3, 1'b0};
      6:       {mono, dx, sens, uart} = {1'b1, 1'b1, 4'd0, 1'b1};
      default: {mono, dx, sens, uart} = 7'($urandom());
    endcase
    write_reg(REG_MONO_MODE, {3'b000, mono});
    write_reg(REG_DX_MODE, {3'b000, dx});
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_LINK_MODE, {3'b000, uart});
    settings_seen++;
  endtask

  // zero, full scale, the saturation edge, grid edges, flag combinations
  task automatic run_directed;
    send_tune(req_t'{28'd0, 1'b0, 1'b0});
    send_tune(req_t'{28'hFFFFFFF, 1'b1, 1'b1});
    send_tune(req_t'{28'd194100000, 1'b0, 1'b0});
    send_tune(req_t'{28'd194099999, 1'b1, 1'b0});
    send_tune(req_t'{28'd87500000, 1'b1, 1'b0});
    send_tune(req_t'{28'd108000000, 1'b0, 1'b1});
    send_tune(req_t'{28'd98100000, 1'b1, 1'b1});
    send_tune(req_t'{28'd12499, 1'b0, 1'b0});
    send_tune(req_t'{28'd12500, 1'b0, 1'b1});
    send_tune(req_t'{28'd1, 1'b1, 1'b1});
  endtask

  function automatic req_t rand_tune();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5)
      r.freq_hz = FreqWidth'($urandom_range(108000000, 87500000));
    else if (pick < 8)
      r.freq_hz = FreqWidth'($urandom());
    else if (pick == 8)
      r.freq_hz = FreqWidth'(194100000 + $urandom_range(4) - 2);
    else
      r.freq_hz = FreqWidth'($urandom_range(20000));
    r.search    = 1'($urandom_range(1));
    r.search_up = 1'($urandom_range(1));
    return r;
  endfunction

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < Phases; p++) begin
      if (p > 0) set_regs(p);
      case (p % 4)
        0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin sender_idle_pct = 66; rsp_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  rsp_stall_pct = 66; end
        default: begin sender_idle_pct = 7;  rsp_stall_pct = 7;  end
      endcase
      // sender keeps offering while the receiver holds off
      if (p == 4) want_holdoff = 1'b1;
      if (p == 0 || p == 2) run_directed();
      repeat (ItemsPerPhase) send_tune(rand_tune());
      drain();
    end
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    repeat (20) @(posedge clk);
    $display("Covered %0d tune requests and %0d results, three-wire and UART frames,",
             requests_seen, results_seen);
    $display("over %0d register settings, four idle mixes and a long receiver hold-off.",
             settings_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
